@@ sv/base64_codec_selectable_alphabet_top_assert.svh @@
// assertion macros for the base64 codec block
// used by the top level; expects clock and active-low reset names as arguments
`ifndef BASE64_CODEC_SELECTABLE_ALPHABET_TOP_ASSERT_SVH
`define BASE64_CODEC_SELECTABLE_ALPHABET_TOP_ASSERT_SVH

// same-cycle implication
`define B64C_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B64C_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/b64c_pkg.sv @@
// shared types, constants and alphabet functions for the base64 codec
// no dependencies
`default_nettype none

package b64c_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam int MAX_RES    = 4;
    localparam int CNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd1;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [1:0]  phase;
        logic [23:0] bits;
        logic [1:0]  pad;
    } group_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic [MAX_RES-1:0][7:0]    bytes;
        logic [MAX_RES-1:0]         lasts;
        logic [MAX_RES-1:0]         bads;
    } group_result_t;

    function automatic logic [7:0] sym62(input logic [2:0] sel);
        logic [7:0] c;
        unique case (sel)
            3'd1:    c = 8'h5F; // _
            3'd2:    c = 8'h2E; // .
            3'd3:    c = 8'h2E; // .
            3'd4:    c = 8'h5F; // _
            3'd5:    c = 8'h5E; // ^
            default: c = 8'h2B; // +
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sym63(input logic [2:0] sel);
        logic [7:0] c;
        unique case (sel)
            3'd1:    c = 8'h2D; // -
            3'd2:    c = 8'h5F; // _
            3'd3:    c = 8'h2D; // -
            3'd4:    c = 8'h3A; // :
            3'd5:    c = 8'h2A; // *
            default: c = 8'h2F; // /
        endcase
        return c;
    endfunction

    function automatic logic [7:0] code_to_char(input logic [5:0] v, input logic [2:0] sel);
        logic [7:0] v8;
        logic [7:0] c;
        v8 = {2'b00, v};
        priority if (v8 < 8'd26) c = 8'h41 + v8;
        else if (v8 < 8'd52)     c = 8'h61 + (v8 - 8'd26);
        else if (v8 < 8'd62)     c = 8'h30 + (v8 - 8'd52);
        else if (v8 == 8'd62)    c = sym62(sel);
        else                     c = sym63(sel);
        return c;
    endfunction

    function automatic logic [5:0] char_to_code(input logic [7:0] c, input logic [2:0] sel);
        logic [7:0] v;
        priority if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A)     v = c - 8'h61 + 8'd26;
        else if (c >= 8'h30 && c <= 8'h39)     v = c - 8'h30 + 8'd52;
        else if (c == sym62(sel))              v = 8'd62;
        else if (c == sym63(sel))              v = 8'd63;
        else                                   v = 8'd0;
        return v[5:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/b64c_step.sv @@
// one-item group step: folds a byte into the group and forms its results
// depends on b64c_pkg
`default_nettype none

module b64c_step
    import b64c_pkg::*;
(
    input  wire logic          mode,
    input  wire logic [2:0]    alpha_sel,
    input  wire group_state_t  state_in,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output group_state_t       state_out,
    output group_result_t      result
);

    logic [1:0]  p_enc;
    logic [23:0] enc_bits;
    logic [23:0] dec_bits;
    logic [5:0]  code;
    logic [1:0]  pad_new;
    logic [1:0]  pad_sat;
    logic [2:0]  dec_count;
    logic [2:0]  chars;

    always_comb begin
        state_out = state_in;
        result    = '0;

        // encode: a stray phase of three folds in as the third byte
        p_enc = (state_in.phase == 2'd3) ? 2'd2 : state_in.phase;
        unique case (p_enc)
            2'd0:    enc_bits = state_in.bits | {in_byte, 16'h0000};
            2'd1:    enc_bits = state_in.bits | {8'h00, in_byte, 8'h00};
            default: enc_bits = state_in.bits | {16'h0000, in_byte};
        endcase
        chars = {1'b0, p_enc} + 3'd2;

        code = char_to_code(in_byte, alpha_sel);
        unique case (state_in.phase)
            2'd0:    dec_bits = state_in.bits | {code, 18'h0};
            2'd1:    dec_bits = state_in.bits | {6'h0, code, 12'h0};
            2'd2:    dec_bits = state_in.bits | {12'h0, code, 6'h0};
            default: dec_bits = state_in.bits | {18'h0, code};
        endcase

        pad_new = state_in.pad;
        if (state_in.phase == 2'd2) begin
            pad_new = (in_byte == PAD_CHAR) ? 2'd1 : 2'd0;
        end else if (state_in.phase == 2'd3 && in_byte == PAD_CHAR) begin
            pad_new = state_in.pad + 2'd1;
        end
        pad_sat   = (pad_new > 2'd2) ? 2'd2 : pad_new;
        dec_count = in_last ? (3'd3 - {1'b0, pad_sat}) : 3'd3;

        if (mode == MODE_ENCODE) begin
            if (p_enc == 2'd2 || in_last) begin
                result.count = 3'd4;
                for (int i = 0; i < MAX_RES; i++) begin
                    result.bytes[i] = (3'(i) < chars)
                        ? code_to_char(enc_bits[23-6*i -: 6], alpha_sel) : PAD_CHAR;
                end
                result.lasts[MAX_RES-1] = in_last;
                state_out = '0;
            end else begin
                state_out.phase = p_enc + 2'd1;
                state_out.bits  = enc_bits;
            end
        end else begin
            if (state_in.phase == 2'd3) begin
                result.count = dec_count;
                for (int i = 0; i < 3; i++) begin
                    result.bytes[i] = dec_bits[23-8*i -: 8];
                end
                result.lasts[dec_count[1:0] - 2'd1] = in_last;
                state_out = '0;
            end else if (in_last) begin
                // partial group dropped, one error beat
                result.count    = 3'd1;
                result.lasts[0] = 1'b1;
                result.bads[0]  = 1'b1;
                state_out = '0;
            end else begin
                state_out.phase = state_in.phase + 2'd1;
                state_out.bits  = dec_bits;
                state_out.pad   = pad_new;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/base64_codec_selectable_alphabet_top.sv @@
// Base64 codec, one byte per input beat. Each accepted beat lands in an input
// register, is folded into the current group in one pass, and a completed
// group or a frame's last beat loads a four-entry result buffer that drains
// one beat per cycle while m_ready is high. Decode sustains one input beat per
// cycle while m_ready stays high; encode is bound by the result port at four
// output beats per three input beats. Input beats that produce no results keep
// flowing while the buffer drains. Config writes are taken at once (cfg_ready is
// tied high); writing the mode register clears the group in progress.
// depends on b64c_pkg, b64c_step and the assertion macro header
`default_nettype none

`include "base64_codec_selectable_alphabet_top_assert.svh"

module base64_codec_selectable_alphabet_top
    import b64c_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_in_byte,
    input  wire logic                  s_in_last,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_out_last,
    output logic                       m_bad_length
);

    logic         mode_reg, mode_next;
    logic [2:0]   alpha_reg, alpha_next;
    group_state_t group_reg, group_next;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg, in_byte_next;
    logic         in_last_reg, in_last_next;

    logic [MAX_RES-1:0][7:0] buf_byte_reg, buf_byte_next;
    logic [MAX_RES-1:0]      buf_last_reg, buf_last_next;
    logic [MAX_RES-1:0]      buf_bad_reg, buf_bad_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    group_state_t  step_state;
    group_result_t step_res;
    logic          emits;
    logic          buf_free;
    logic          proc;
    logic          pop;
    logic          load;

    b64c_step u_step (
        .mode      (mode_reg),
        .alpha_sel (alpha_reg),
        .state_in  (group_reg),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .state_out (step_state),
        .result    (step_res)
    );

    assign cfg_ready    = 1'b1;
    assign m_valid      = (cnt_reg != '0);
    assign m_out_byte   = buf_byte_reg[0];
    assign m_out_last   = buf_last_reg[0];
    assign m_bad_length = buf_bad_reg[0];

    assign pop      = m_valid && m_ready;
    assign emits    = (step_res.count != '0);
    assign buf_free = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && m_ready);
    assign proc     = in_valid_reg && (!emits || buf_free);
    assign load     = proc && emits;
    assign s_ready  = !in_valid_reg || proc;

    always_comb begin
        mode_next  = mode_reg;
        alpha_next = alpha_reg;
        group_next = group_reg;
        if (proc) begin
            group_next = step_state;
        end
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODE: begin
                    mode_next  = cfg_data[0];
                    group_next = '0;
                end
                CFG_ALPHA: alpha_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (proc) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_in_byte;
            in_last_next  = s_in_last;
        end
    end

    always_comb begin
        buf_byte_next = buf_byte_reg;
        buf_last_next = buf_last_reg;
        buf_bad_next  = buf_bad_reg;
        cnt_next      = cnt_reg;
        priority if (load) begin
            buf_byte_next = step_res.bytes;
            buf_last_next = step_res.lasts;
            buf_bad_next  = step_res.bads;
            cnt_next      = step_res.count;
        end else if (pop) begin
            // shift the queue toward the head
            for (int i = 0; i < MAX_RES - 1; i++) begin
                buf_byte_next[i] = buf_byte_reg[i+1];
                buf_last_next[i] = buf_last_reg[i+1];
                buf_bad_next[i]  = buf_bad_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_ENCODE;
            alpha_reg    <= '0;
            group_reg    <= '0;
            in_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            mode_reg     <= mode_next;
            alpha_reg    <= alpha_next;
            group_reg    <= group_next;
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg  <= in_byte_next;
        in_last_reg  <= in_last_next;
        buf_byte_reg <= buf_byte_next;
        buf_last_reg <= buf_last_next;
        buf_bad_reg  <= buf_bad_next;
    end

    `B64C_ASSERT_IMPLIES(a_bad_is_last, aclk, aresetn, m_valid && m_bad_length, m_out_last, "error beat without last mark")
    `B64C_ASSERT_IMPLIES(a_enc_no_bad, aclk, aresetn, m_valid && mode_reg == MODE_ENCODE, !m_bad_length, "error flag while encoding")
    `B64C_ASSERT_IMPLIES(a_last_drains, aclk, aresetn, m_valid && m_out_last, cnt_reg == CNT_W'(1), "last beat not at end of buffer")
    `B64C_ASSERT_NEXT(a_load_count, aclk, aresetn, load, cnt_reg == $past(step_res.count), "buffer count wrong after load")

endmodule

`default_nettype wire
